FILE: rtl/mec_pkg.sv
`default_nettype none

package mec_pkg;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int RADIUS_W  = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 2'd1;

  // radius squared reset: 4.0 in Q6.26
  localparam logic [RADIUS_W-1:0] RADIUS_SQ_RST = 32'd268435456;

  // radius is held in Q6.26
  localparam int RADIUS_FRAC = 26;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ITER = 2'b10
  } mec_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } mec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stop;
  } mec_status_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = hi[DATA_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[DATA_W-1:0];
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mec_ctrl.sv
`default_nettype none

module mec_ctrl
  import mec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire mec_status_t status_i,
  output mec_cmd_t         cmd_o,
  output logic             busy,
  output logic             out_valid
);

  mec_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // sequencing: load on start, iterate until the datapath flags a stop
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_ITER;
        end
      end
      ST_ITER: begin
        if (status_i.stop) begin
          cmd_o.finish = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd_o.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/mec_datapath.sv
`default_nettype none

module mec_datapath
  import mec_pkg::*;
#(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire mec_cmd_t                 cmd_i,
  output mec_status_t                   status_o,
  input  wire logic signed [DATA_W-1:0] in_c_re,
  input  wire logic signed [DATA_W-1:0] in_c_im,
  input  wire logic [RADIUS_W-1:0]      radius_sq_i,
  input  wire logic [COUNT_WIDTH-1:0]   max_iter_i,
  output logic [COUNT_WIDTH-1:0]        out_iterations
);

  localparam int MAG_SHIFT = 2 * FRAC_BITS - RADIUS_FRAC;

  logic signed [DATA_W-1:0] z_re_r, z_re_nxt;
  logic signed [DATA_W-1:0] z_im_r, z_im_nxt;
  logic signed [DATA_W-1:0] c_re_r, c_im_r;
  logic [COUNT_WIDTH-1:0]   count_r, count_nxt;
  logic [COUNT_WIDTH-1:0]   iter_out_r;

  logic signed [63:0] z_re_w, z_im_w;
  logic signed [63:0] rr, ii, ri;
  logic signed [63:0] re_sum, im_sum;
  logic [63:0]        mag, mag_q;

  // complex square of the current z
  always_comb begin
    z_re_w = 64'(z_re_r);
    z_im_w = 64'(z_im_r);
    rr     = z_re_w * z_re_w;
    ii     = z_im_w * z_im_w;
    ri     = z_re_w * z_im_w;
  end

  // next z: floor shift back to Q4.28, add c, clamp
  always_comb begin
    re_sum   = ((rr - ii) >>> FRAC_BITS) + 64'(c_re_r);
    im_sum   = (ri >>> (FRAC_BITS - 1)) + 64'(c_im_r);
    z_re_nxt = sat32(re_sum);
    z_im_nxt = sat32(im_sum);
  end

  // |z|^2 of the current z, scaled to Q6.26 for the radius test;
  // z here is the result of iteration count_r
  always_comb begin
    mag   = 64'(rr) + 64'(ii);
    mag_q = mag >> MAG_SHIFT;
    status_o.stop = (count_r != '0) &&
                    ((mag_q >= 64'(radius_sq_i)) || (count_r >= max_iter_i));
  end

  always_comb begin
    count_nxt = count_r + COUNT_WIDTH'(1);
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      z_re_r  <= '0;
      z_im_r  <= '0;
      c_re_r  <= in_c_re;
      c_im_r  <= in_c_im;
      count_r <= '0;
    end else if (cmd_i.step) begin
      z_re_r  <= z_re_nxt;
      z_im_r  <= z_im_nxt;
      count_r <= count_nxt;
    end
    if (cmd_i.finish) begin
      iter_out_r <= count_r;
    end
  end

  assign out_iterations = iter_out_r;

endmodule

`default_nettype wire

FILE: rtl/mandelbrot_escape_count_top.sv
// Mandelbrot escape-time counter. busy rises once a start beat is taken and stays
// high while the z loop runs (complex square, add c, clamp; one iteration per
// cycle) and while the escape test of the last z is made; the result strobe
// comes in the next cycle, as busy falls. A new point is taken only while idle,
// which includes the strobe cycle, so each point is finished before the next.
// rst_n is synchronous: control idles, radius_sq 4.0, max_iter 256; no output stall.
`default_nettype none

module mandelbrot_escape_count_top
  import mec_pkg::*;
#(
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DATA_W-1:0] in_c_re,
  input  wire logic signed [DATA_W-1:0] in_c_im,
  output logic                          out_valid,
  output logic [COUNT_WIDTH-1:0]        out_iterations,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata
);

  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RST =
    (COUNT_WIDTH > 8) ? COUNT_WIDTH'(256) : {COUNT_WIDTH{1'b1}};

  logic [RADIUS_W-1:0]    radius_sq_r;
  logic [COUNT_WIDTH-1:0] max_iter_r;
  mec_cmd_t               cmd;
  mec_status_t            status;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_sq_r <= RADIUS_SQ_RST;
      max_iter_r  <= MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS_SQ: radius_sq_r <= cfg_wdata[RADIUS_W-1:0];
        REG_MAX_ITER:  max_iter_r  <= cfg_wdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mec_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_c_re        (in_c_re),
    .in_c_im        (in_c_im),
    .radius_sq_i    (radius_sq_r),
    .max_iter_i     (max_iter_r),
    .out_iterations (out_iterations)
  );

  // every point runs at least one iteration, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  // a result carries a count of at least one
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_iterations != '0))
    else $error("result with zero iterations");

  // the strobe comes as the block returns to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe while busy");

  // an accepted beat starts work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted point did not start");

endmodule

`default_nettype wire

FILE: dv/mandelbrot_escape_count_top_test.sv
module mandelbrot_escape_count_top_test;
  import mec_pkg::*;

  localparam int FRAC = 28;
  localparam int CNT_W = 16;
  localparam int STALL_LIMIT = 200000;
  localparam logic [CNT_W-1:0] ITER_LIMIT_RST = 16'd256;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

  // handy Q4.28 points
  localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_ZERO  = 32'sh0000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh1000_0000;
  localparam logic signed [DATA_W-1:0] Q_M_ONE = 32'shF000_0000;
  localparam logic signed [DATA_W-1:0] Q_TWO   = 32'sh2000_0000;
  localparam logic signed [DATA_W-1:0] Q_M_TWO = 32'shE000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } point_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [DATA_W-1:0] in_c_re;
  logic signed [DATA_W-1:0] in_c_im;
  logic out_valid;
  logic [CNT_W-1:0] out_iterations;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // shadow of the register file
  logic [RADIUS_W-1:0] radius_q;
  logic [CNT_W-1:0] iter_limit;

  point_t points_pending[$];
  logic [CNT_W-1:0] counts_due[$];

  int gap_left = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;
  bit fail_seen = 1'b0;

  mandelbrot_escape_count_top #(
    .FRAC_BITS(FRAC),
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_c_re(in_c_re),
    .in_c_im(in_c_im),
    .out_valid(out_valid),
    .out_iterations(out_iterations),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clamp to the signed Q4.28 range
  function automatic longint clamp_q428(input longint v);
    if (v > longint'(Q_MAX)) return longint'(Q_MAX);
    if (v < longint'(Q_MIN)) return longint'(Q_MIN);
    return v;
  endfunction

  // iterate z = z^2 + c until |z|^2 reaches the radius or the limit is hit
  function automatic logic [CNT_W-1:0] escape_count(input logic signed [DATA_W-1:0] cr,
                                                    input logic signed [DATA_W-1:0] ci);
    longint zr;
    longint zi;
    longint nr;
    longint ni;
    logic [63:0] mag;
    int unsigned n;
    bit stop;
    zr = 0;
    zi = 0;
    n = 0;
    stop = 1'b0;
    while (!stop) begin
      // floor shifts: >>> on a signed longint rounds toward minus infinity
      nr = clamp_q428(((zr * zr - zi * zi) >>> FRAC) + longint'(cr));
      ni = clamp_q428(((zr * zi) >>> (FRAC - 1)) + longint'(ci));
      mag = nr * nr + ni * ni;
      n++;
      zr = nr;
      zi = ni;
      stop = ((mag >> (2 * FRAC - RADIUS_FRAC)) >= 64'(radius_q)) || (n >= iter_limit);
    end
    return n[CNT_W-1:0];
  endfunction

  // mostly points around the set, some anywhere in the Q4.28 range
  function automatic point_t pick_point();
    point_t p;
    if ($urandom_range(9) < 2) begin
      p.re = $urandom;
      p.im = $urandom;
    end else begin
      p.re = $urandom_range(32'h4800_0000) - 32'h2400_0000;
      p.im = $urandom_range(32'h4800_0000) - 32'h2400_0000;
    end
    return p;
  endfunction

  task automatic add_point(input logic signed [DATA_W-1:0] re,
                           input logic signed [DATA_W-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    points_pending.push_back(p);
  endtask

  task automatic add_random(input int count);
    for (int i = 0; i < count; i++) points_pending.push_back(pick_point());
  endtask

  // register write, mirrored into the shadow copy; only called while idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RADIUS_SQ: radius_q = val;
      REG_MAX_ITER: iter_limit = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (points_pending.size() != 0 || counts_due.size() != 0) @(negedge clk);
  endtask

  // point driver: holds start until the beat is taken, unless an idle burst drops it
  always @(negedge clk) begin
    if (gap_left != 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (points_pending.size() != 0) begin
      if (idle_on && $urandom_range(15) == 0) begin
        gap_left = $urandom_range(18);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_c_re <= points_pending[0].re;
        in_c_im <= points_pending[0].im;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict on each accepted point, check each result strobe
  always @(posedge clk) begin : monitor
    logic [CNT_W-1:0] want;
    if (rst_n) begin
      if (start && !busy) begin
        counts_due.push_back(escape_count(in_c_re, in_c_im));
        void'(points_pending.pop_front());
      end
      if (out_valid) begin
        if (counts_due.size() == 0) begin
          $error("iterations: no result expected, got %0d", out_iterations);
          fail_seen = 1'b1;
        end else begin
          want = counts_due.pop_front();
          if (out_iterations !== want) begin
            $error("iterations: expected %0d, got %0d", want, out_iterations);
            fail_seen = 1'b1;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [RADIUS_W-1:0] rad;
    logic [CNT_W-1:0] lim;
    rst_n = 1'b0;
    start = 1'b0;
    in_c_re = '0;
    in_c_im = '0;
    cfg_we = 1'b0;
    cfg_index = REG_RADIUS_SQ;
    cfg_wdata = '0;
    radius_q = RADIUS_SQ_RST;
    iter_limit = ITER_LIMIT_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes, points in and out of the set
    add_point(Q_ZERO, Q_ZERO);
    add_point(Q_MIN, Q_MIN);
    add_point(Q_MAX, Q_MAX);
    add_point(Q_MAX, Q_MIN);
    add_point(Q_MIN, Q_ZERO);
    add_point(Q_ZERO, Q_MAX);
    add_point(Q_M_TWO, Q_ZERO);
    add_point(Q_TWO, Q_ZERO);
    add_point(32'sh0400_0000, Q_ZERO);
    add_point(Q_M_ONE, Q_ZERO);
    add_point(Q_ZERO, Q_ONE);
    add_point(32'shF400_0000, 32'sh0199_999A);
    add_point(32'sh04CC_CCCD, 32'sh0800_0000);
    add_point(32'shE400_0000, Q_ZERO);
    add_point(32'sh0000_0001, 32'shFFFF_FFFF);
    add_point(32'sh0400_0001, 32'sh0000_0001);
    wait_drained();

    // zero radius: everything escapes at once; unmapped writes change nothing
    cfg_write(REG_RADIUS_SQ, 32'd0);
    cfg_write(REG_UNMAPPED_A, 32'hFFFF_FFFF);
    cfg_write(REG_UNMAPPED_B, 32'h0000_0001);
    add_point(Q_ZERO, Q_ZERO);
    add_point(Q_MIN, Q_MAX);
    add_point(32'sh0000_0001, 32'shFFFF_FFFF);
    wait_drained();

    // zero limit behaves as one, upper data bits dropped
    cfg_write(REG_RADIUS_SQ, RADIUS_SQ_RST);
    cfg_write(REG_MAX_ITER, 32'hFFFF_0000);
    add_point(Q_ZERO, Q_ZERO);
    add_point(Q_M_ONE, Q_ZERO);
    wait_drained();

    cfg_write(REG_MAX_ITER, 32'd1);
    add_point(Q_ZERO, Q_ZERO);
    wait_drained();

    // widest radius, just under 64.0 in Q6.26
    cfg_write(REG_RADIUS_SQ, 32'hFFFF_FFFF);
    cfg_write(REG_MAX_ITER, 32'd40);
    for (int i = 0; i < 50; i++) add_point($urandom, $urandom);
    add_random(50);
    wait_drained();

    // largest limit: one point that never escapes, a few that do
    cfg_write(REG_RADIUS_SQ, RADIUS_SQ_RST);
    cfg_write(REG_MAX_ITER, 32'h0000_FFFF);
    add_point(Q_ZERO, Q_ZERO);
    add_point(Q_TWO, Q_ONE);
    for (int i = 0; i < 2; i++) add_point($urandom, $urandom);
    wait_drained();

    // random phases, each under its own settings
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(3))
        0: rad = $urandom;
        1: rad = 32'h0400_0000;
        2: rad = RADIUS_SQ_RST;
        default: rad = $urandom_range(32'h2000_0000);
      endcase
      lim = ($urandom_range(4) == 0) ? 16'd2 : 16'($urandom_range(1, 320));
      idle_on = ($urandom_range(3) != 0);
      if (k == 7) begin
        rad = RADIUS_SQ_RST;
        lim = ITER_LIMIT_RST;
        idle_on = 1'b0;
      end
      cfg_write(REG_RADIUS_SQ, rad);
      cfg_write(REG_MAX_ITER, {16'($urandom), lim});
      add_random(228);
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (!fail_seen && counts_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
